### hdl/smvb_pkg.sv
// Shared types, constants and saturation helpers of the vertex blend core.
package smvb_pkg;

  localparam int MaxBonesDef = 64;
  localparam int FracBitsDef = 16;
  localparam int ElemCount   = 6;
  localparam int WeightBits  = 16;
  localparam int OpW         = 33;
  localparam int ProdW       = 64;

  localparam logic [16:0] WeightOne = 17'h10000;

  // Request kinds carried in req_type.
  localparam logic ReqMatrix    = 1'b0;
  localparam logic ReqInfluence = 1'b1;

  // Bone matrix element codes.
  localparam logic [2:0] ElemA  = 3'd0;
  localparam logic [2:0] ElemB  = 3'd1;
  localparam logic [2:0] ElemC  = 3'd2;
  localparam logic [2:0] ElemD  = 3'd3;
  localparam logic [2:0] ElemTx = 3'd4;
  localparam logic [2:0] ElemTy = 3'd5;

  // Sequencer steps, named after the matrix element read data holds in that cycle.
  localparam logic [3:0] StepA    = 4'd0;
  localparam logic [3:0] StepC    = 4'd1;
  localparam logic [3:0] StepTx   = 4'd2;
  localparam logic [3:0] StepB    = 4'd3;
  localparam logic [3:0] StepD    = 4'd4;
  localparam logic [3:0] StepTy   = 4'd5;
  localparam logic [3:0] StepSumX = 4'd6;
  localparam logic [3:0] StepMulY = 4'd7;
  localparam logic [3:0] StepSumY = 4'd8;

  localparam logic signed [63:0] S32Max = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32Min = -64'sh0000_0000_8000_0000;
  localparam logic signed [48:0] S48Max = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] S48Min = -49'sh0_8000_0000_0000;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StSums,
    StEmit
  } state_e;

  typedef struct packed {
    logic               req_type;
    logic        [5:0]  bone_index;
    logic        [2:0]  matrix_elem;
    logic signed [31:0] matrix_value;
    logic signed [31:0] local_x;
    logic signed [31:0] local_y;
    logic signed [31:0] deform_x;
    logic signed [31:0] deform_y;
    logic        [16:0] weight;
    logic               last_influence;
    logic               last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               bounds_valid;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic        [31:0] box_width;
    logic        [31:0] box_height;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32Max) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32Min) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v > S48Max) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < S48Min) begin
      r = -48'sh8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

### hdl/smvb_if.sv
// Valid/ready channel interfaces for the input and result items.
interface smvb_in_if;
  logic                valid;
  logic                ready;
  smvb_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface smvb_out_if;
  logic                valid;
  logic                ready;
  smvb_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hdl/smvb_bone_mem.sv
// Bone matrix table: one write port and one registered read port.
module smvb_bone_mem #(
  parameter int DEPTH = smvb_pkg::MaxBonesDef * smvb_pkg::ElemCount,
  parameter int AW    = $clog2(smvb_pkg::MaxBonesDef * smvb_pkg::ElemCount)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic signed [31:0] wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output logic signed [31:0] rdata_o
);

  logic signed [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/smvb_mul.sv
// Shared signed multiplier with a registered product.
module smvb_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [smvb_pkg::OpW-1:0]      a_i,
  input  logic signed [smvb_pkg::OpW-1:0]      b_i,
  output logic signed [smvb_pkg::ProdW-1:0]    prod_o
);
  import smvb_pkg::*;

  logic signed [2*OpW-1:0] full;

  // Operands never exceed 32 magnitude bits, so the low word holds the exact product.
  assign full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= full[ProdW-1:0];
    end
  end

endmodule

### hdl/skinned_mesh_vertex_blend_core.sv
// Top level of the 2D linear blend skinning core with running bounding box.
//
//   Channel | Role   | Handshake    | Item
//   --------+--------+--------------+---------------------------------------------
//   in_i    | sink   | valid/ready  | bone matrix element write or vertex influence
//   out_o   | source | valid/ready  | blended vertex, plus the mesh box on the last
//
// A matrix write is taken without leaving the idle state. An influence holds ready
// low after it is accepted while the sequencer runs its steps; a last influence
// then passes through the sums and emit states to form and emit the vertex. The
// run is set by the six products of an influence sharing one multiplier and by
// the bone table delivering one element per cycle through its single read port.
// Reset clears the sums and the box and leaves the bone table undefined.
// A held result stalls only the emit step; no item is accepted while that step waits.
module skinned_mesh_vertex_blend_core #(
  parameter int MAX_BONES = smvb_pkg::MaxBonesDef,
  parameter int FRAC_BITS = smvb_pkg::FracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  smvb_in_if.sink  in_i,
  smvb_out_if.source out_o
);
  import smvb_pkg::*;

  localparam int Depth = MAX_BONES * ElemCount;
  localparam int AW    = $clog2(Depth);

  state_e state_q, state_d;
  logic [3:0] step_q, step_d;

  // Captured influence operands.
  logic signed [31:0] xl_q, yl_q;
  logic        [16:0] w_q;
  logic        [5:0]  bone_q;
  logic               bone_ok_q, last_inf_q, last_vtx_q;

  // Datapath registers.
  logic signed [63:0] t_q;
  logic signed [31:0] hold_q, tx_q, ty_q;
  logic signed [47:0] sum_x_q, sum_y_q;
  logic signed [31:0] ox_q, oy_q;
  logic signed [31:0] low_x_q, high_x_q, low_y_q, high_y_q;
  logic               out_valid_q;
  out_item_t          out_q, out_d;

  logic               in_fire, infl_fire, bone_ok_in, mem_we;
  logic [2:0]         seq_elem;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] rd_data, rd_elem;
  logic signed [OpW-1:0]   op_a, op_b;
  logic signed [ProdW-1:0] prod, prod_fl, weighted;
  logic signed [63:0] t_add, t_fin;
  logic signed [48:0] sum_x_add, sum_y_add;
  logic signed [32:0] xl_sum, yl_sum;
  logic signed [31:0] nlx, nhx, nly, nhy;
  logic               out_free, emit_fire;

  assign in_i.ready    = (state_q == StIdle);
  assign in_fire       = in_i.valid && in_i.ready;
  assign infl_fire     = in_fire && (in_i.payload.req_type == ReqInfluence);
  assign bone_ok_in    = int'(in_i.payload.bone_index) < MAX_BONES;
  assign mem_we        = in_fire && (in_i.payload.req_type == ReqMatrix) && bone_ok_in &&
                         (int'(in_i.payload.matrix_elem) < ElemCount);
  assign waddr         = AW'(int'(in_i.payload.bone_index) * ElemCount +
                             int'(in_i.payload.matrix_elem));

  // Element fetch order: a, c, tx, b, d, ty. The first fetch is issued on acceptance.
  always_comb begin
    case (step_q)
      StepA:   seq_elem = ElemC;
      StepC:   seq_elem = ElemTx;
      StepTx:  seq_elem = ElemB;
      StepB:   seq_elem = ElemD;
      StepD:   seq_elem = ElemTy;
      default: seq_elem = ElemA;
    endcase
    if (state_q == StIdle) begin
      raddr = AW'(int'(in_i.payload.bone_index) * ElemCount + int'(ElemA));
    end else begin
      raddr = AW'(int'(bone_q) * ElemCount + int'(seq_elem));
    end
  end

  smvb_bone_mem #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_bone_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (in_i.payload.matrix_value),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // A bone beyond the table reads as an all-zero matrix.
  assign rd_elem = bone_ok_q ? rd_data : 32'sd0;

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = OpW'(rd_elem);
    op_b = OpW'(xl_q);
    case (step_q)
      StepC, StepD: op_b = OpW'(yl_q);
      StepTy: begin
        op_a = OpW'(tx_q);
        op_b = OpW'($signed({1'b0, w_q}));
      end
      StepMulY: begin
        op_a = OpW'(ty_q);
        op_b = OpW'($signed({1'b0, w_q}));
      end
      default: ;
    endcase
  end

  smvb_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (state_q == StRun),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  assign prod_fl   = prod >>> FRAC_BITS;
  assign weighted  = prod >>> WeightBits;
  assign t_add     = t_q + prod_fl;
  assign t_fin     = t_q + 64'(hold_q);
  assign sum_x_add = sum_x_q + 49'(weighted);
  assign sum_y_add = sum_y_q + 49'(weighted);
  assign xl_sum    = in_i.payload.local_x + in_i.payload.deform_x;
  assign yl_sum    = in_i.payload.local_y + in_i.payload.deform_y;

  // Box after folding in the finished vertex.
  assign nlx = (ox_q < low_x_q)  ? ox_q : low_x_q;
  assign nhx = (ox_q > high_x_q) ? ox_q : high_x_q;
  assign nly = (oy_q < low_y_q)  ? oy_q : low_y_q;
  assign nhy = (oy_q > high_y_q) ? oy_q : high_y_q;

  assign out_free  = !out_valid_q || out_o.ready;
  assign emit_fire = (state_q == StEmit) && out_free;

  always_comb begin
    out_d              = '0;
    out_d.out_x        = ox_q;
    out_d.out_y        = oy_q;
    if (last_vtx_q) begin
      out_d.bounds_valid = 1'b1;
      out_d.min_x        = nlx;
      out_d.min_y        = nly;
      out_d.box_width    = 32'(nhx - nlx);
      out_d.box_height   = 32'(nhy - nly);
    end
  end

  // Sequencer: next state and step.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StIdle: begin
        if (infl_fire) begin
          state_d = StRun;
          step_d  = StepA;
        end
      end
      StRun: begin
        step_d = step_q + 4'd1;
        if (step_q == StepSumY) begin
          state_d = last_inf_q ? StSums : StIdle;
        end
      end
      StSums: state_d = StEmit;
      StEmit: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= StepA;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Accumulators, box and output handshake state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      low_x_q     <= 32'sh7FFF_FFFF;
      low_y_q     <= 32'sh7FFF_FFFF;
      high_x_q    <= -32'sh8000_0000;
      high_y_q    <= -32'sh8000_0000;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == StRun && step_q == StepSumX) begin
        sum_x_q <= sat48(sum_x_add);
      end
      if (state_q == StRun && step_q == StepSumY) begin
        sum_y_q <= sat48(sum_y_add);
      end
      if (state_q == StSums) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
      end
      if (emit_fire) begin
        if (last_vtx_q) begin
          low_x_q  <= 32'sh7FFF_FFFF;
          low_y_q  <= 32'sh7FFF_FFFF;
          high_x_q <= -32'sh8000_0000;
          high_y_q <= -32'sh8000_0000;
        end else begin
          low_x_q  <= nlx;
          low_y_q  <= nly;
          high_x_q <= nhx;
          high_y_q <= nhy;
        end
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers. The product of a step is registered and used in the next step, so
  // x is finished while b*x is being formed and y while tx*w is added to the x sum.
  always_ff @(posedge clk_i) begin
    if (infl_fire) begin
      xl_q       <= sat32(64'(xl_sum));
      yl_q       <= sat32(64'(yl_sum));
      w_q        <= (in_i.payload.weight > WeightOne) ? WeightOne : in_i.payload.weight;
      bone_q     <= in_i.payload.bone_index;
      bone_ok_q  <= bone_ok_in;
      last_inf_q <= in_i.payload.last_influence;
      last_vtx_q <= in_i.payload.last_vertex;
    end
    if (state_q == StRun) begin
      case (step_q)
        StepC, StepD: t_q <= prod_fl;
        StepTx, StepTy: begin
          t_q    <= t_add;
          hold_q <= rd_elem;
        end
        StepB:    tx_q <= sat32(t_fin);
        StepSumX: ty_q <= sat32(t_fin);
        default: ;
      endcase
    end
    if (state_q == StSums) begin
      ox_q <= sat32(64'(sum_x_q));
      oy_q <= sat32(-(64'(sum_y_q)));
    end
    if (emit_fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule
